@@ rtl/core/pdem_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdem_pkg
// Widths, constants and types shared by the elastic moduli pipeline.
// ----------------------------------------------------------------------------
package pdem_pkg;

  // field widths
  localparam int STRESS_W   = 40;
  localparam int TRACE_W    = 42;
  localparam int NEGP_W     = 41;
  localparam int P_W        = 40;
  localparam int VOID_W     = 18;
  localparam int COEF_W     = 24;
  localparam int ATM_W      = 24;
  localparam int NU_W       = 15;
  localparam int MOD_W      = 48;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SHEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NU    = 2'd2;

  localparam logic [COEF_W-1:0] RST_SHEAR = 24'd8192000;
  localparam logic [ATM_W-1:0]  RST_ATM   = 24'd25600;
  localparam logic [NU_W-1:0]   RST_NU    = 15'd3277;

  // datapath widths
  localparam int DD_W       = 36;
  localparam int R_W        = 36;
  localparam int PP_W       = 64;
  localparam int AR_W       = COEF_W + R_W;
  localparam int AR_SHIFT   = 32;
  localparam int A_W        = AR_W - AR_SHIFT;
  localparam int Q16_SHIFT  = 16;
  localparam int NU2_W      = NU_W + 1;

  // divide by three through the reciprocal (2^48-1)/3
  localparam int RCP_W      = 88;
  localparam int RCP_SHIFT  = 48;

  // long divider
  localparam int DIV_N_W    = 60;
  localparam int DIV_D_W    = 19;
  localparam int DIV_SIDE_W = 44;

  // square root
  localparam int SQ_RAD_W   = 64;
  localparam int SQ_ROOT_W  = SQ_RAD_W / 2;
  localparam int SQ_REM_W   = SQ_ROOT_W + 2;
  localparam int SQ_SIDE_W  = A_W;

  localparam int GQ_W       = A_W + SQ_ROOT_W;
  localparam int G_W        = GQ_W - Q16_SHIFT;
  localparam int NUM_W      = NU2_W + G_W;

  localparam logic [VOID_W-1:0] FIX_2_97 = 18'd194642;
  localparam logic [16:0]       ONE_Q16  = 17'd65536;
  localparam logic [MOD_W-1:0]  MOD_MAX  = {MOD_W{1'b1}};

  typedef struct packed {
    logic [COEF_W-1:0] shear_coeff;
    logic [ATM_W-1:0]  atm;
    logic [NU_W-1:0]   nu;
  } cfg_t;

endpackage

@@ rtl/core/pdem_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdem interfaces
// Valid/ready channels for stress words, moduli words and register writes.
// ----------------------------------------------------------------------------
interface pdem_in_if import pdem_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [STRESS_W-1:0] stress_xx;
  logic signed [STRESS_W-1:0] stress_yy;
  logic signed [STRESS_W-1:0] stress_zz;
  logic [VOID_W-1:0]          void_ratio;

  modport source (output valid, stress_xx, stress_yy, stress_zz, void_ratio, input ready);
  modport sink (input valid, stress_xx, stress_yy, stress_zz, void_ratio, output ready);
endinterface

interface pdem_out_if import pdem_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] normal_modulus;
  logic [MOD_W-1:0] lateral_modulus;
  logic [MOD_W-1:0] shear_modulus;

  modport source (output valid, normal_modulus, lateral_modulus, shear_modulus,
                  input ready);
  modport sink (input valid, normal_modulus, lateral_modulus, shear_modulus,
                output ready);
endinterface

interface pdem_cfg_if import pdem_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/pdem_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdem_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module pdem_div import pdem_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [DIV_N_W-1:0]    dividend,
  input  logic [DIV_D_W-1:0]    divisor,
  input  logic [DIV_SIDE_W-1:0] side_in,
  output logic                  out_vld,
  output logic [DIV_N_W-1:0]    quotient,
  output logic [DIV_SIDE_W-1:0] side_out
);

  logic                  vld_r  [DIV_N_W];
  logic [DIV_D_W-1:0]    rem_r  [DIV_N_W];
  logic [DIV_N_W-1:0]    work_r [DIV_N_W];
  logic [DIV_D_W-1:0]    dvs_r  [DIV_N_W];
  logic [DIV_SIDE_W-1:0] side_r [DIV_N_W];

  genvar k;
  generate
    for (k = 0; k < DIV_N_W; k++) begin : g_stage
      logic                  vld_in;
      logic [DIV_D_W-1:0]    rem_in;
      logic [DIV_N_W-1:0]    work_in;
      logic [DIV_D_W-1:0]    dvs_in;
      logic [DIV_SIDE_W-1:0] sd_in;
      logic [DIV_D_W:0]      trial;
      logic                  take;
      logic [DIV_D_W-1:0]    rem_nxt;
      logic [DIV_N_W-1:0]    work_nxt;

      if (k == 0) begin : g_head
        assign vld_in  = in_vld;
        assign rem_in  = '0;
        assign work_in = dividend;
        assign dvs_in  = divisor;
        assign sd_in   = side_in;
      end else begin : g_body
        assign vld_in  = vld_r[k-1];
        assign rem_in  = rem_r[k-1];
        assign work_in = work_r[k-1];
        assign dvs_in  = dvs_r[k-1];
        assign sd_in   = side_r[k-1];
      end

      // work word shifts dividend bits out the top, quotient bits in the bottom
      always_comb begin
        trial    = {rem_in, work_in[DIV_N_W-1]};
        take     = (trial >= {1'b0, dvs_in});
        rem_nxt  = take ? DIV_D_W'(trial - {1'b0, dvs_in}) : trial[DIV_D_W-1:0];
        work_nxt = {work_in[DIV_N_W-2:0], take};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= vld_in;
        end
        if (en) begin
          rem_r[k]  <= rem_nxt;
          work_r[k] <= work_nxt;
          dvs_r[k]  <= dvs_in;
          side_r[k] <= sd_in;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[DIV_N_W-1];
  assign quotient = work_r[DIV_N_W-1];
  assign side_out = side_r[DIV_N_W-1];

endmodule

@@ rtl/core/pdem_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdem_sqrt
// Pipelined integer square root, one root bit per stage, with side data.
// ----------------------------------------------------------------------------
module pdem_sqrt import pdem_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [SQ_RAD_W-1:0]  radicand,
  input  logic [SQ_SIDE_W-1:0] side_in,
  output logic                 out_vld,
  output logic [SQ_ROOT_W-1:0] root,
  output logic [SQ_SIDE_W-1:0] side_out
);

  logic                 vld_r  [SQ_ROOT_W];
  logic [SQ_REM_W-1:0]  rem_r  [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] root_r [SQ_ROOT_W];
  logic [SQ_RAD_W-1:0]  rad_r  [SQ_ROOT_W];
  logic [SQ_SIDE_W-1:0] side_r [SQ_ROOT_W];

  genvar k;
  generate
    for (k = 0; k < SQ_ROOT_W; k++) begin : g_stage
      logic                  vld_in;
      logic [SQ_REM_W-1:0]   rem_in;
      logic [SQ_ROOT_W-1:0]  root_in;
      logic [SQ_RAD_W-1:0]   rad_in;
      logic [SQ_SIDE_W-1:0]  sd_in;
      logic [SQ_REM_W+1:0]   rem_sh;
      logic [SQ_REM_W+1:0]   trial;
      logic                  take;
      logic [SQ_REM_W-1:0]   rem_nxt;
      logic [SQ_ROOT_W-1:0]  root_nxt;
      logic [SQ_RAD_W-1:0]   rad_nxt;

      if (k == 0) begin : g_head
        assign vld_in  = in_vld;
        assign rem_in  = '0;
        assign root_in = '0;
        assign rad_in  = radicand;
        assign sd_in   = side_in;
      end else begin : g_body
        assign vld_in  = vld_r[k-1];
        assign rem_in  = rem_r[k-1];
        assign root_in = root_r[k-1];
        assign rad_in  = rad_r[k-1];
        assign sd_in   = side_r[k-1];
      end

      // bring down two radicand bits, try root*4+1
      always_comb begin
        rem_sh   = {rem_in, rad_in[SQ_RAD_W-1 -: 2]};
        trial    = (SQ_REM_W+2)'({root_in, 2'b01});
        take     = (rem_sh >= trial);
        rem_nxt  = take ? SQ_REM_W'(rem_sh - trial) : rem_sh[SQ_REM_W-1:0];
        root_nxt = {root_in[SQ_ROOT_W-2:0], take};
        rad_nxt  = {rad_in[SQ_RAD_W-3:0], 2'b00};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= vld_in;
        end
        if (en) begin
          rem_r[k]  <= rem_nxt;
          root_r[k] <= root_nxt;
          rad_r[k]  <= rad_nxt;
          side_r[k] <= sd_in;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[SQ_ROOT_W-1];
  assign root     = root_r[SQ_ROOT_W-1];
  assign side_out = side_r[SQ_ROOT_W-1];

endmodule

@@ rtl/core/pressure_dependent_elastic_moduli_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_dependent_elastic_moduli_unit
// Hardin-type shear modulus and the isotropic stiffness entries per word.
// ----------------------------------------------------------------------------
// Accepts one stress word per cycle unless the output holds, and returns one
// moduli word per input word, in order. The pipeline is two input stages, a
// 60-stage divider for the void ratio term with the negated trace riding
// alongside, three stages that divide the pressure by three through a
// reciprocal multiply, two stages, a 32-stage square root, two stages, a
// 60-stage divider for lambda and the output register. The whole pipeline
// holds while the output word waits; no word is lost or repeated.
// Configuration writes are taken at any time (ready is always high) and must
// only be issued when the pipeline is empty.
module pressure_dependent_elastic_moduli_unit import pdem_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pdem_in_if.sink     in_ch,
  pdem_out_if.source  out_ch,
  pdem_cfg_if.sink    cfg_ch
);

  cfg_t cfg_r;
  logic en;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{shear_coeff: RST_SHEAR, atm: RST_ATM, nu: RST_NU};
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SHEAR: cfg_r.shear_coeff <= cfg_ch.data[COEF_W-1:0];
        CFG_ATM:   cfg_r.atm         <= cfg_ch.data[ATM_W-1:0];
        CFG_NU:    cfg_r.nu          <= cfg_ch.data[NU_W-1:0];
        default: ;
      endcase
    end
  end

  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: negated trace and distance of e from 2.97
  logic signed [TRACE_W-1:0] trace;
  logic signed [TRACE_W-1:0] neg_trace;
  logic [NEGP_W-1:0]         np_nxt;
  logic [VOID_W-1:0]         ad_nxt;

  assign trace     = TRACE_W'(in_ch.stress_xx) + TRACE_W'(in_ch.stress_yy)
                   + TRACE_W'(in_ch.stress_zz);
  assign neg_trace = -trace;
  assign np_nxt    = trace[TRACE_W-1] ? neg_trace[NEGP_W-1:0] : '0;
  assign ad_nxt    = (in_ch.void_ratio <= FIX_2_97) ? (FIX_2_97 - in_ch.void_ratio)
                                                    : (in_ch.void_ratio - FIX_2_97);

  logic              v1_r;
  logic [NEGP_W-1:0] np1_r;
  logic [VOID_W-1:0] e1_r;
  logic [VOID_W-1:0] ad1_r;

  // stage 2: square, divisor 1+e, negated trace plus one
  logic               v2_r;
  logic [NEGP_W-1:0]  np2_r;
  logic [DD_W-1:0]    dd2_r;
  logic [DIV_D_W-1:0] dvs2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
    end
    if (en) begin
      np1_r  <= np_nxt;
      e1_r   <= in_ch.void_ratio;
      ad1_r  <= ad_nxt;
      np2_r  <= np1_r + NEGP_W'(1);
      dd2_r  <= DD_W'(ad1_r) * DD_W'(ad1_r);
      dvs2_r <= DIV_D_W'(ONE_Q16) + DIV_D_W'(e1_r);
    end
  end

  // void ratio term, negated trace travels as side data
  logic                  v3;
  logic [DIV_N_W-1:0]    r3q;
  logic [DIV_SIDE_W-1:0] x3_side;

  pdem_div u_div_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v2_r),
    .dividend (DIV_N_W'({dd2_r, {Q16_SHIFT{1'b0}}})),
    .divisor  (dvs2_r),
    .side_in  (DIV_SIDE_W'(np2_r)),
    .out_vld  (v3),
    .quotient (r3q),
    .side_out (x3_side)
  );

  // mean pressure: (np+1) * (2^48-1)/3 >> 48 equals floor(np/3),
  // the constant is built by doubling a 0101 bit pattern
  logic             va_r, vb_r, vc_r;
  logic [RCP_W-1:0] x3, t1, t3_nxt, t5;
  logic [RCP_W-1:0] ta_r, tb3_r, tb4_r;
  logic [P_W-1:0]   pc_r;
  logic [R_W-1:0]   ra_r, rb_r, rc_r;

  assign x3     = RCP_W'(x3_side[NEGP_W-1:0]);
  assign t1     = x3 + (x3 << 2);
  assign t3_nxt = ta_r + (ta_r << 8);
  assign t5     = tb4_r + (tb3_r << 32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= v3;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
    if (en) begin
      ta_r  <= t1 + (t1 << 4);
      tb3_r <= t3_nxt;
      tb4_r <= t3_nxt + (t3_nxt << 16);
      pc_r  <= t5[RCP_W-1:RCP_SHIFT];
      ra_r  <= r3q[R_W-1:0];
      rb_r  <= ra_r;
      rc_r  <= rb_r;
    end
  end

  // stage 4: clamp at atmospheric; stage 5: p*patm and G0*r
  logic            v4_r, v5_r;
  logic [P_W-1:0]  p4_r;
  logic [R_W-1:0]  r4_r;
  logic [PP_W-1:0] pp_full;
  logic [AR_W-1:0] ar_full;
  logic [PP_W-1:0] pp5_r;
  logic [A_W-1:0]  a5_r;

  assign pp_full = PP_W'(p4_r) * PP_W'(cfg_r.atm);
  assign ar_full = AR_W'(cfg_r.shear_coeff) * AR_W'(r4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= vc_r;
      v5_r <= v4_r;
    end
    if (en) begin
      p4_r  <= (pc_r < P_W'(cfg_r.atm)) ? P_W'(cfg_r.atm) : pc_r;
      r4_r  <= rc_r;
      pp5_r <= pp_full;
      a5_r  <= ar_full[AR_W-1:AR_SHIFT];
    end
  end

  logic                 v6;
  logic [SQ_ROOT_W-1:0] q6;
  logic [A_W-1:0]       a6;

  pdem_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v5_r),
    .radicand (pp5_r),
    .side_in  (a5_r),
    .out_vld  (v6),
    .root     (q6),
    .side_out (a6)
  );

  // stage 7: G; stage 8: 2*nu*G and divisor 1-2*nu
  logic               v7_r, v8_r;
  logic [GQ_W-1:0]    gq_full;
  logic [G_W-1:0]     g7_r, g8_r;
  logic [NU2_W-1:0]   nu2;
  logic [NUM_W-1:0]   num_full;
  logic [NUM_W-1:0]   num8_r;
  logic [DIV_D_W-1:0] dvl8_r;

  assign gq_full  = GQ_W'(a6) * GQ_W'(q6);
  assign nu2      = {cfg_r.nu, 1'b0};
  assign num_full = NUM_W'(nu2) * NUM_W'(g7_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6;
      v8_r <= v7_r;
    end
    if (en) begin
      g7_r   <= gq_full[GQ_W-1:Q16_SHIFT];
      num8_r <= num_full;
      g8_r   <= g7_r;
      dvl8_r <= DIV_D_W'(ONE_Q16) - DIV_D_W'(nu2);
    end
  end

  logic                  v9;
  logic [DIV_N_W-1:0]    lam9;
  logic [DIV_SIDE_W-1:0] g9;

  pdem_div u_div_lam (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v8_r),
    .dividend (DIV_N_W'(num8_r)),
    .divisor  (dvl8_r),
    .side_in  (DIV_SIDE_W'(g8_r)),
    .out_vld  (v9),
    .quotient (lam9),
    .side_out (g9)
  );

  // output register, saturating the normal and lateral moduli
  logic [DIV_N_W:0] nrm_sum;
  logic [MOD_W-1:0] nrm_r, lat_r, shr_r;

  assign nrm_sum = (DIV_N_W+1)'(lam9) + (DIV_N_W+1)'({g9, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= v9;
    end
    if (en) begin
      nrm_r <= (nrm_sum > (DIV_N_W+1)'(MOD_MAX)) ? MOD_MAX : nrm_sum[MOD_W-1:0];
      lat_r <= (lam9 > DIV_N_W'(MOD_MAX)) ? MOD_MAX : lam9[MOD_W-1:0];
      shr_r <= MOD_W'(g9);
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.normal_modulus  = nrm_r;
  assign out_ch.lateral_modulus = lat_r;
  assign out_ch.shear_modulus   = shr_r;

  a_shear_le_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.shear_modulus <= out_ch.normal_modulus)
    else $error("shear modulus above normal modulus");

  a_lateral_le_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.lateral_modulus <= out_ch.normal_modulus)
    else $error("lateral modulus above normal modulus");

endmodule
